// File: design/assert_macros.svh
// Assertion macros shared by the host aging table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property, sampled on clk_i, off while rst_ni is low.
`define HAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Overlapping implication.
`define HAT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define HAT_ASSERT(lbl, prop, msg)
`define HAT_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

// File: design/hat_pkg.sv
// Package with types and constants for the host aging table.
`timescale 1ns / 1ps
package hat_pkg;

  localparam int TableEntriesDef = 64;
  localparam int NameBytesDef    = 3;

  localparam int NAME_PORT_W = 24;
  localparam int MAC_W       = 48;
  localparam int TTL_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;

  localparam logic [TTL_W-1:0] RELOAD_DEF = 8'd15;

  localparam logic OP_HEARTBEAT = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESHED = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_DROPPED   = 2'd2,
    ST_TICK      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   expired;
    logic [COUNT_W-1:0]   live;
  } hat_result_t;

endpackage

// File: design/hat_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module hat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/hat_scan.sv
// Sequencer that walks the table memories for each request.
`timescale 1ns / 1ps
module hat_scan import hat_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int NAME_BYTES    = NameBytesDef,
  localparam int IdxW  = $clog2(TABLE_ENTRIES),
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1),
  localparam int NameW = (NAME_BYTES * 8 < NAME_PORT_W) ? NAME_BYTES * 8 : NAME_PORT_W,
  localparam int StW   = TTL_W + 1,
  localparam int DtW   = NameW + MAC_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [NAME_PORT_W-1:0] host_name_i,
  input  logic [MAC_W-1:0]       host_mac_i,
  input  logic [TTL_W-1:0]       reload_i,
  input  logic                   out_free_i,
  output logic                   res_load_o,
  output hat_result_t            res_o,
  output logic                   rd_en_o,
  output logic [IdxW-1:0]        rd_addr_o,
  output logic                   st_we_o,
  output logic [IdxW-1:0]        st_waddr_o,
  output logic [StW-1:0]         st_wdata_o,
  input  logic [StW-1:0]         st_rdata_i,
  output logic                   dt_we_o,
  output logic [IdxW-1:0]        dt_waddr_o,
  output logic [DtW-1:0]         dt_wdata_o,
  input  logic [DtW-1:0]         dt_rdata_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  state_e state_q, state_d;

  logic             op_q, op_d;
  logic [NameW-1:0] name_q, name_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic             issue_q, issue_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]  chk_idx_q, chk_idx_d;
  logic             free_found_q, free_found_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [CntW-1:0]  expired_q, expired_d;
  logic [CntW-1:0]  live_q, live_d;
  hat_result_t      res_q, res_d;

  logic             scan_end;
  logic             clear_end;
  logic             ent_valid;
  logic [TTL_W-1:0] ent_ttl;
  logic [TTL_W-1:0] ttl_dec;
  logic             is_last;
  logic [IdxW-1:0]  free_sel;
  logic [CntW-1:0]  exp_n;
  logic [CntW-1:0]  live_n;

  assign ent_valid = st_rdata_i[TTL_W];
  assign ent_ttl   = st_rdata_i[TTL_W-1:0];
  assign ttl_dec   = (ent_ttl != '0) ? ent_ttl - 1'b1 : '0;
  assign is_last   = (chk_idx_q == LastIdx);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clear_end) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_DONE;
      S_DONE:  if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_d         = op_q;
    name_d       = name_q;
    mac_d        = mac_q;
    issue_d      = issue_q;
    idx_d        = idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    expired_d    = expired_q;
    live_d       = live_q;
    res_d        = res_q;
    scan_end     = 1'b0;
    clear_end    = 1'b0;
    in_ready_o   = 1'b0;
    res_load_o   = 1'b0;
    rd_en_o      = 1'b0;
    rd_addr_o    = idx_q;
    st_we_o      = 1'b0;
    st_waddr_o   = chk_idx_q;
    st_wdata_o   = '0;
    dt_we_o      = 1'b0;
    dt_waddr_o   = chk_idx_q;
    dt_wdata_o   = {name_q, mac_q};
    free_sel     = free_found_q ? free_idx_q : chk_idx_q;
    exp_n        = expired_q;
    live_n       = live_q;

    unique case (state_q)
      S_CLEAR: begin
        st_we_o    = 1'b1;
        st_waddr_o = idx_q;
        if (idx_q == LastIdx) begin
          clear_end = 1'b1;
          idx_d     = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = operation_i;
          name_d       = host_name_i[NameW-1:0];
          mac_d        = host_mac_i;
          issue_d      = 1'b1;
          idx_d        = '0;
          free_found_d = 1'b0;
          expired_d    = '0;
        end
      end
      S_SCAN: begin
        rd_en_o   = issue_q;
        chk_vld_d = issue_q;
        if (issue_q) begin
          if (idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (chk_vld_q) begin
          if (op_q == OP_TICK) begin
            if (ent_valid) begin
              st_we_o = 1'b1;
              if (ttl_dec == '0) begin
                st_wdata_o = '0;
                exp_n      = expired_q + 1'b1;
                live_n     = live_q - 1'b1;
              end else begin
                st_wdata_o = {1'b1, ttl_dec};
              end
            end
            expired_d = exp_n;
            live_d    = live_n;
            if (is_last) begin
              scan_end = 1'b1;
              res_d    = '{status: ST_TICK, slot: '0,
                           expired: COUNT_W'(exp_n), live: COUNT_W'(live_n)};
            end
          end else begin
            if (ent_valid && dt_rdata_i[DtW-1:MAC_W] == name_q) begin
              // refresh: TTL reloaded, MAC kept
              st_we_o    = 1'b1;
              st_wdata_o = {1'b1, reload_i};
              scan_end   = 1'b1;
              issue_d    = 1'b0;
              chk_vld_d  = 1'b0;
              res_d      = '{status: ST_REFRESHED, slot: SLOT_W'(chk_idx_q),
                             expired: '0, live: COUNT_W'(live_q)};
            end else begin
              if (!ent_valid && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = chk_idx_q;
              end
              if (is_last) begin
                scan_end = 1'b1;
                if (free_found_q || !ent_valid) begin
                  st_we_o    = 1'b1;
                  st_waddr_o = free_sel;
                  st_wdata_o = {1'b1, reload_i};
                  dt_we_o    = 1'b1;
                  dt_waddr_o = free_sel;
                  live_n     = live_q + 1'b1;
                  live_d     = live_n;
                  res_d      = '{status: ST_INSERTED, slot: SLOT_W'(free_sel),
                                 expired: '0, live: COUNT_W'(live_n)};
                end else begin
                  res_d = '{status: ST_DROPPED, slot: '0,
                            expired: '0, live: COUNT_W'(live_q)};
                end
              end
            end
          end
        end
      end
      S_DONE: begin
        res_load_o = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      issue_q      <= 1'b0;
      idx_q        <= '0;
      chk_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      expired_q    <= '0;
      live_q       <= '0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      idx_q        <= idx_d;
      chk_vld_q    <= chk_vld_d;
      free_found_q <= free_found_d;
      expired_q    <= expired_d;
      live_q       <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    name_q     <= name_d;
    mac_q      <= mac_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

endmodule

// File: design/host_aging_table_core.sv
// Top level of the host aging table: memories, config register, result register.
//
//  chan | handshake                 | payload                                         | dir
//  -----+---------------------------+-------------------------------------------------+----
//  in   | in_valid_i / in_ready_o   | operation_i, host_name_i, host_mac_i            | in
//  out  | out_valid_o / out_ready_i | status_o, slot_o, expired_count_o, live_count_o | out
//  cfg  | cfg_valid_i / cfg_ready_o | cfg_data_i, the TTL reload value                | in
//
// Walk: each request walks the table, one entry per cycle through the one read port
// of the state memories. A tick, an insert or a dropped heartbeat walks the whole
// table; a refresh of slot k ends the walk at slot k.
// One request is in the walk at a time; the next is taken once the result has moved
// to the output register, while that result may still wait for out_ready_i.
// Reset: a clearing pass over all TABLE_ENTRIES entries frees every entry; in_ready_o
// stays low meanwhile, while cfg writes are taken at all times.
// Stalls: a held output stalls the result hand-off and so the next request, not the walk.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module host_aging_table_core import hat_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int NAME_BYTES    = NameBytesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [NAME_PORT_W-1:0] host_name_i,
  input  logic [MAC_W-1:0]       host_mac_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [SLOT_W-1:0]      slot_o,
  output logic [COUNT_W-1:0]     expired_count_o,
  output logic [COUNT_W-1:0]     live_count_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [TTL_W-1:0]       cfg_data_i
);

  localparam int IdxW  = $clog2(TABLE_ENTRIES);
  localparam int NameW = (NAME_BYTES * 8 < NAME_PORT_W) ? NAME_BYTES * 8 : NAME_PORT_W;
  localparam int StW   = TTL_W + 1;           // {valid, ttl}
  localparam int DtW   = NameW + MAC_W;       // {name, mac}

  logic [TTL_W-1:0] ttl_reload_q, ttl_reload_d;
  logic [TTL_W-1:0] reload;

  logic             out_valid_q, out_valid_d;
  hat_result_t      out_q;
  logic             out_free;
  logic             res_load;
  hat_result_t      res;

  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             st_we;
  logic [IdxW-1:0]  st_waddr;
  logic [StW-1:0]   st_wdata;
  logic [StW-1:0]   st_rdata;
  logic             dt_we;
  logic [IdxW-1:0]  dt_waddr;
  logic [DtW-1:0]   dt_wdata;
  logic [DtW-1:0]   dt_rdata;

  // config register; a reload of zero behaves as one
  assign cfg_ready_o  = 1'b1;
  assign ttl_reload_d = cfg_valid_i ? cfg_data_i : ttl_reload_q;
  assign reload       = (ttl_reload_q == '0) ? TTL_W'(1) : ttl_reload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_reload_q <= RELOAD_DEF;
    end else begin
      ttl_reload_q <= ttl_reload_d;
    end
  end

  // walk sequencer
  hat_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_BYTES    (NAME_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .host_name_i (host_name_i),
    .host_mac_i  (host_mac_i),
    .reload_i    (reload),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .st_we_o     (st_we),
    .st_waddr_o  (st_waddr),
    .st_wdata_o  (st_wdata),
    .st_rdata_i  (st_rdata),
    .dt_we_o     (dt_we),
    .dt_waddr_o  (dt_waddr),
    .dt_wdata_o  (dt_wdata),
    .dt_rdata_i  (dt_rdata)
  );

  // valid bit and TTL per entry
  hat_ram #(
    .WIDTH (StW),
    .DEPTH (TABLE_ENTRIES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  // name and MAC per entry, never cleared
  hat_ram #(
    .WIDTH (DtW),
    .DEPTH (TABLE_ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (dt_waddr),
    .wdata_i (dt_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (dt_rdata)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign slot_o          = out_q.slot;
  assign expired_count_o = out_q.expired;
  assign live_count_o    = out_q.live;

  // checks
  `HAT_ASSERT_IMP(a_load_when_free, res_load, !out_valid_q || out_ready_i, "result overwrote a pending one")
  `HAT_ASSERT_IMP(a_expired_tick_only, out_valid_o && status_o != ST_TICK, expired_count_o == '0, "expired count on heartbeat")
  `HAT_ASSERT_IMP(a_slot_zero, out_valid_o && (status_o == ST_DROPPED || status_o == ST_TICK), slot_o == '0, "slot set on drop or tick")
  `HAT_ASSERT(a_no_accept_in_walk, !(in_ready_o && res_load), "input taken during result hand-off")

endmodule

// File: sim/host_aging_table_checker.sv
// Checker for the host aging table: mirrors the table, predicts each result and compares.
`timescale 1ns / 1ps
module host_aging_table_checker import hat_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   operation_i,
  input  logic [NAME_PORT_W-1:0] host_name_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [STATUS_W-1:0]    status_i,
  input  logic [SLOT_W-1:0]      slot_i,
  input  logic [COUNT_W-1:0]     expired_count_i,
  input  logic [COUNT_W-1:0]     live_count_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [TTL_W-1:0]       cfg_data_i,
  output int                     pending_o,
  output int                     errors_o
);

  localparam logic [63:0] NameMask = (NameBytesDef >= 8) ? '1 :
                                     ((64'd1 << (8 * NameBytesDef)) - 64'd1);

  // mirror of the table
  logic                   host_live [TableEntriesDef];
  logic [TTL_W-1:0]       ttl_left  [TableEntriesDef];
  logic [NAME_PORT_W-1:0] host_name [TableEntriesDef];
  logic [TTL_W-1:0]       reload_q;

  hat_result_t awaited_results [$];
  hat_result_t oldest;
  int          mismatches;

  function automatic hat_result_t update_host_table(input logic op,
                                                    input logic [NAME_PORT_W-1:0] name);
    hat_result_t            res;
    logic [TTL_W-1:0]       fresh;
    logic [NAME_PORT_W-1:0] key;
    logic                   done;
    int                     freed;
    int                     live;
    res   = '0;
    fresh = (reload_q == '0) ? TTL_W'(1) : reload_q;
    key   = name & NameMask[NAME_PORT_W-1:0];
    done  = 1'b0;
    freed = 0;
    live  = 0;
    if (op == OP_TICK) begin
      for (int i = 0; i < TableEntriesDef; i++) begin
        if (host_live[i]) begin
          if (ttl_left[i] != '0) ttl_left[i] = ttl_left[i] - 1'b1;
          if (ttl_left[i] == '0) begin
            host_live[i] = 1'b0;
            freed++;
          end
        end
      end
      res.status = ST_TICK;
    end else begin
      // free slots keep stale names; only live ones may match
      for (int i = 0; i < TableEntriesDef && !done; i++) begin
        if (host_live[i] && host_name[i] == key) begin
          ttl_left[i] = fresh;
          res.status  = ST_REFRESHED;
          res.slot    = SLOT_W'(i);
          done        = 1'b1;
        end
      end
      for (int i = 0; i < TableEntriesDef && !done; i++) begin
        if (!host_live[i]) begin
          host_live[i] = 1'b1;
          ttl_left[i]  = fresh;
          host_name[i] = key;
          res.status   = ST_INSERTED;
          res.slot     = SLOT_W'(i);
          done         = 1'b1;
        end
      end
      if (!done) res.status = ST_DROPPED;
    end
    for (int i = 0; i < TableEntriesDef; i++) if (host_live[i]) live++;
    res.expired = COUNT_W'(freed);
    res.live    = COUNT_W'(live);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntriesDef; i++) begin
        host_live[i] = 1'b0;
        ttl_left[i]  = '0;
      end
      reload_q = RELOAD_DEF;
      awaited_results.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // retire before accepting, so a stray result never pairs with a fresh request
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d slot %0d",
                 status_i, slot_i);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status_i);
            mismatches++;
          end
          if (slot_i !== oldest.slot) begin
            $error("slot: expected %0d, actual %0d", oldest.slot, slot_i);
            mismatches++;
          end
          if (expired_count_i !== oldest.expired) begin
            $error("expired_count: expected %0d, actual %0d",
                   oldest.expired, expired_count_i);
            mismatches++;
          end
          if (live_count_i !== oldest.live) begin
            $error("live_count: expected %0d, actual %0d", oldest.live, live_count_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(update_host_table(operation_i, host_name_i));
      if (cfg_valid_i && cfg_ready_i) reload_q = cfg_data_i;
      pending_o <= awaited_results.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// File: sim/host_aging_table_core_tb.sv
// Testbench top for host_aging_table_core: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module host_aging_table_core_tb;
  import hat_pkg::*;

  localparam int PoolMax = 100;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   operation_i = OP_HEARTBEAT;
  logic [NAME_PORT_W-1:0] host_name_i = '0;
  logic [MAC_W-1:0]       host_mac_i  = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [SLOT_W-1:0]      slot_o;
  logic [COUNT_W-1:0]     expired_count_o;
  logic [COUNT_W-1:0]     live_count_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [TTL_W-1:0]       cfg_data_i  = '0;

  int   pending;
  int   errors;
  // while set, neither side idles: back-to-back requests, result port always open
  logic calm = 1'b0;

  logic [NAME_PORT_W-1:0] name_pool [PoolMax];
  int                     pool_n;

  host_aging_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .host_name_i     (host_name_i),
    .host_mac_i      (host_mac_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .expired_count_o (expired_count_o),
    .live_count_o    (live_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  host_aging_table_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .operation_i     (operation_i),
    .host_name_i     (host_name_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .slot_i          (slot_o),
    .expired_count_i (expired_count_o),
    .live_count_i    (live_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side back-pressure: out_ready_i low with a chance of 6 in 100, never while calm.
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 6);

  // Hard stop. The slowest legal run (~1700 requests, stalls included) is near 2.5 ms;
  // this leaves several times that.
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  // One request on the input channel. Optional idle gap first; valid then stays
  // high with a fixed payload until the edge that takes it. Returns in the step
  // of that edge, so a following call keeps valid high without a glitch.
  task automatic send_request(input logic op, input logic [NAME_PORT_W-1:0] name,
                              input logic [MAC_W-1:0] mac);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    host_name_i <= name;
    host_mac_i  <= mac;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Tick payload fields are don't-care; randomize them anyway.
  task automatic send_tick();
    send_request(OP_TICK, NAME_PORT_W'($urandom), random_mac());
  endtask

  // Hold off until every outstanding request has produced its result.
  // pending is registered, so wait on the clock before the first look.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Reload value may change only with the table walk idle.
  task automatic write_reload(input logic [TTL_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic fill_pool(input int n);
    pool_n = n;
    for (int k = 0; k < n; k++) name_pool[k] = NAME_PORT_W'($urandom);
    // keep the all-zero and all-one names in play now and then
    if ($urandom_range(1)) name_pool[0] = '0;
    if ($urandom_range(1)) name_pool[n-1] = '1;
  endtask

  initial begin
    logic [TTL_W-1:0] phase_reload [10];
    logic [31:0]      w;
    int               tick_pct;
    phase_reload = '{8'd255, 8'd15, 8'd2, 8'd255, 8'd40, 8'd1, 8'd128, 8'd7, 8'd200, 8'd3};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed ----
    // default reload of 15 after reset
    send_request(OP_HEARTBEAT, '0, '0);                    // insert slot 0
    send_request(OP_HEARTBEAT, '1, '1);                    // insert slot 1
    send_request(OP_HEARTBEAT, '0, random_mac());          // refresh slot 0, new MAC ignored
    send_tick();                                           // both down to 14
    // zero reload behaves as one: entries survive only to the next tick
    write_reload('0);
    send_request(OP_HEARTBEAT, 24'h123456, random_mac());  // insert slot 2, ttl 1
    send_request(OP_HEARTBEAT, '0, '1);                    // refresh slot 0, ttl 1
    send_tick();                                           // slots 0 and 2 age out
    // slot 2 is free but still holds the old name; it must not match, and
    // the lowest free slot (0) takes the host
    send_request(OP_HEARTBEAT, 24'h123456, '0);
    send_request(OP_HEARTBEAT, '1, random_mac());          // refresh slot 1, ttl 1
    send_tick();                                           // table empty again

    // ---- random ----
    // Reload 1, then more distinct hosts than slots: fills all 64, drops the
    // overflow, and one tick frees the whole table at once.
    write_reload(8'd1);
    for (int k = 0; k < TableEntriesDef + 2; k++) begin
      w = $urandom;
      send_request(OP_HEARTBEAT, {w[15:0], k[7:0]}, random_mac());
    end
    send_tick();

    // Phases: each with its own reload, tick density and host population.
    // Small pools mostly refresh; pools above 64 overflow the table.
    for (int p = 0; p < 10; p++) begin
      write_reload(phase_reload[p]);
      fill_pool($urandom_range(PoolMax, 4));
      tick_pct = (phase_reload[p] > 100) ? $urandom_range(8, 1) : $urandom_range(35, 5);
      calm = (p == 2);
      for (int k = 0; k < 160; k++) begin
        // now and then let the block run completely dry before the next request
        if (!calm && $urandom_range(199) == 0) drain();
        if ($urandom_range(99) < tick_pct)
          send_tick();
        else if ($urandom_range(99) < 88)
          send_request(OP_HEARTBEAT, name_pool[$urandom_range(pool_n - 1)], random_mac());
        else
          send_request(OP_HEARTBEAT, NAME_PORT_W'($urandom), random_mac());
      end
      calm = 1'b0;
    end

    drain();
    // margin for a late or extra result: one full table walk and then some
    repeat (TableEntriesDef + 16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
